/* hw/rtl/fsda_pkg.sv */
// Shared constants and types of the fixed-scale decimal arithmetic unit.
package fsda_pkg;

  localparam int unsigned MAX_SCALE = 18;

  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_SUB = 3'd1;
  localparam logic [2:0] KIND_MUL = 3'd2;
  localparam logic [2:0] KIND_DIV = 3'd3;
  localparam logic [2:0] KIND_CMP = 3'd4;
  localparam logic [2:0] KIND_NEG = 3'd5;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_OVF     = 3'd1;
  localparam logic [2:0] ST_SCALE   = 3'd2;
  localparam logic [2:0] ST_DIVZERO = 3'd3;
  localparam logic [2:0] ST_INEXACT = 3'd4;

  localparam logic [1:0] ORD_LESS    = 2'd0;
  localparam logic [1:0] ORD_EQUAL   = 2'd1;
  localparam logic [1:0] ORD_GREATER = 2'd2;

  // Largest magnitude that can still be multiplied by ten without overflow.
  localparam logic [63:0] LIM_TIMES10 = 64'd922337203685477580;
  localparam logic [63:0] MAG_MIN     = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAG_MAXPOS  = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic done;
    logic exact;
  } div_stat_t;

endpackage

/* hw/rtl/fixed_scale_decimal_alu.sv */
// Top level of the fixed-scale decimal arithmetic unit.
// One beat in gives one beat out; the unit works on one item at a time and holds
// in_stall_o high until its result beat has been taken. Add, subtract and compare
// align their scales one decimal place at a time; multiply runs a bit-serial
// shift-add loop; negate needs no loop. Every division, whether a divide trial or
// the removal of one trailing zero, uses the shared bit-serial divider. A divide
// costs up to nineteen trials; a trial whose alignment overflows is dropped before
// it reaches the divider. Each check for a trailing zero runs the divider,
// including the last one that finds none while the scale is still above zero.
module fixed_scale_decimal_alu
  import fsda_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [63:0] a_coefficient_i,
  input  logic [4:0]  a_scale_i,
  input  logic [63:0] b_coefficient_i,
  input  logic [4:0]  b_scale_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] result_coefficient_o,
  output logic [4:0]  result_scale_o,
  output logic [1:0]  order_o,
  output logic [2:0]  status_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_ALIGN  = 4'd2;
  localparam logic [3:0] S_ADD    = 4'd3;
  localparam logic [3:0] S_MUL    = 4'd4;
  localparam logic [3:0] S_MULCHK = 4'd5;
  localparam logic [3:0] S_TRIAL  = 4'd6;
  localparam logic [3:0] S_DSCALE = 4'd7;
  localparam logic [3:0] S_DWAIT  = 4'd8;
  localparam logic [3:0] S_STRIP  = 4'd9;
  localparam logic [3:0] S_SWAIT  = 4'd10;
  localparam logic [3:0] S_CSCALE = 4'd11;
  localparam logic [3:0] S_CCMP   = 4'd12;
  localparam logic [3:0] S_OUT    = 4'd13;

  localparam logic [4:0] MAX_S = 5'(MAX_SCALE);

  logic [3:0]   state_q, state_d;
  logic [2:0]   kind_q, kind_d;
  logic [63:0]  ac_q, ac_d, bc_q, bc_d;
  logic [4:0]   as_q, as_d, bs_q, bs_d;
  logic [63:0]  ma_q, ma_d, mb_q, mb_d;
  logic         sb_q, sb_d;
  logic         sel_a_q, sel_a_d;
  logic [6:0]   cnt_q, cnt_d;
  logic [4:0]   s_q, s_d;
  logic [63:0]  p_q, p_d, q_q, q_d;
  logic [127:0] w_q, w_d;
  logic [63:0]  rm_q, rm_d;
  logic         rn_q, rn_d;
  logic [4:0]   rs_q, rs_d;
  logic [1:0]   order_q, order_d;
  logic [2:0]   st_q, st_d;

  logic [63:0]  mag_a, mag_b, tgt, tgt10;
  logic         tgt_ovf, minneg1, div_start;
  logic [63:0]  div_num, div_den, div_quot;
  div_stat_t    div_stat;
  logic [64:0]  sum65, msum;
  logic [63:0]  addend;
  logic [6:0]   e;
  logic [127:0] lhs, rhs;
  logic         lt, gt;

  assign mag_a   = ac_q[63] ? 64'(~ac_q + 64'd1) : ac_q;
  assign mag_b   = bc_q[63] ? 64'(~bc_q + 64'd1) : bc_q;
  assign tgt     = sel_a_q ? ma_q : mb_q;
  assign tgt_ovf = tgt > LIM_TIMES10;
  assign tgt10   = 64'((tgt << 3) + (tgt << 1));
  assign minneg1 = ac_q[63] && (ma_q == MAG_MIN) && bc_q[63] && (mb_q == 64'd1);
  assign sum65   = {1'b0, ma_q} + {1'b0, mb_q};
  assign addend  = q_q[0] ? ma_q : 64'd0;
  assign msum    = {1'b0, p_q} + {1'b0, addend};
  assign e       = {2'b0, bs_q} + {2'b0, s_q} - {2'b0, as_q};
  assign lhs     = sel_a_q ? w_q : {64'd0, ma_q};
  assign rhs     = sel_a_q ? {64'd0, mb_q} : w_q;
  assign lt      = lhs < rhs;
  assign gt      = lhs > rhs;

  assign div_start = ((state_q == S_STRIP) && (rm_q != 64'd0) && (rs_q != 5'd0)) ||
                     ((state_q == S_DSCALE) && (cnt_q == 7'd0) && !minneg1);
  assign div_num   = (state_q == S_STRIP) ? rm_q : ma_q;
  assign div_den   = (state_q == S_STRIP) ? 64'd10 : mb_q;

  fsda_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quot_o  (div_quot),
    .stat_o  (div_stat)
  );

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    ac_d    = ac_q;
    bc_d    = bc_q;
    as_d    = as_q;
    bs_d    = bs_q;
    ma_d    = ma_q;
    mb_d    = mb_q;
    sb_d    = sb_q;
    sel_a_d = sel_a_q;
    cnt_d   = cnt_q;
    s_d     = s_q;
    p_d     = p_q;
    q_d     = q_q;
    w_d     = w_q;
    rm_d    = rm_q;
    rn_d    = rn_q;
    rs_d    = rs_q;
    order_d = order_q;
    st_d    = st_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d  = kind_i;
          ac_d    = a_coefficient_i;
          bc_d    = b_coefficient_i;
          as_d    = a_scale_i;
          bs_d    = b_scale_i;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        st_d    = ST_OK;
        order_d = ORD_EQUAL;
        rm_d    = '0;
        rn_d    = 1'b0;
        rs_d    = '0;
        ma_d    = mag_a;
        mb_d    = mag_b;
        state_d = S_OUT;
        if (kind_q <= KIND_NEG &&
            (as_q > MAX_S || (kind_q != KIND_NEG && bs_q > MAX_S))) begin
          st_d = ST_SCALE;
        end else begin
          case (kind_q)
            KIND_ADD, KIND_SUB: begin
              if (kind_q == KIND_SUB && bc_q == MAG_MIN) begin
                st_d = ST_OVF;
              end else begin
                sb_d = (kind_q == KIND_SUB) ? !bc_q[63] : bc_q[63];
                if (as_q >= bs_q) begin
                  sel_a_d = 1'b0;
                  cnt_d   = {2'b0, as_q - bs_q};
                  rs_d    = as_q;
                end else begin
                  sel_a_d = 1'b1;
                  cnt_d   = {2'b0, bs_q - as_q};
                  rs_d    = bs_q;
                end
                state_d = S_ALIGN;
              end
            end
            KIND_MUL: begin
              if (({1'b0, as_q} + {1'b0, bs_q}) > {1'b0, MAX_S}) begin
                st_d = ST_SCALE;
              end else begin
                p_d     = '0;
                q_d     = mag_b;
                cnt_d   = 7'd64;
                state_d = S_MUL;
              end
            end
            KIND_DIV: begin
              if (mag_b == 64'd0) begin
                st_d = ST_DIVZERO;
              end else begin
                s_d     = '0;
                state_d = S_TRIAL;
              end
            end
            KIND_CMP: begin
              if (ac_q[63] && !bc_q[63]) begin
                order_d = ORD_LESS;
              end else if (!ac_q[63] && bc_q[63]) begin
                order_d = ORD_GREATER;
              end else begin
                sel_a_d = as_q < bs_q;
                w_d     = {64'd0, (as_q < bs_q) ? mag_a : mag_b};
                cnt_d   = {2'b0, (as_q < bs_q) ? bs_q - as_q : as_q - bs_q};
                state_d = S_CSCALE;
              end
            end
            KIND_NEG: begin
              if (ac_q == MAG_MIN) begin
                st_d = ST_OVF;
              end else begin
                rn_d = !ac_q[63];
                rm_d = mag_a;
                rs_d = as_q;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_ALIGN: begin
        if (cnt_q == 7'd0) begin
          state_d = S_ADD;
        end else if (tgt_ovf) begin
          st_d    = ST_OVF;
          state_d = S_OUT;
        end else begin
          if (sel_a_q) begin
            ma_d = tgt10;
          end else begin
            mb_d = tgt10;
          end
          cnt_d = cnt_q - 7'd1;
        end
      end
      S_ADD: begin
        state_d = S_STRIP;
        if (ac_q[63] == sb_q) begin
          rm_d = sum65[63:0];
          rn_d = sb_q;
          if (sb_q ? (sum65 > {1'b0, MAG_MIN}) : (sum65 > {1'b0, MAG_MAXPOS})) begin
            st_d    = ST_OVF;
            state_d = S_OUT;
          end
        end else if (ma_q >= mb_q) begin
          rm_d = ma_q - mb_q;
          rn_d = ac_q[63];
        end else begin
          rm_d = mb_q - ma_q;
          rn_d = sb_q;
        end
      end
      S_MUL: begin
        p_d   = msum[64:1];
        q_d   = {msum[0], q_q[63:1]};
        cnt_d = cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          state_d = S_MULCHK;
        end
      end
      S_MULCHK: begin
        rn_d    = ac_q[63] ^ bc_q[63];
        rm_d    = q_q;
        rs_d    = 5'(as_q + bs_q);
        state_d = S_STRIP;
        if (p_q != 64'd0 || q_q > ((ac_q[63] ^ bc_q[63]) ? MAG_MIN : MAG_MAXPOS)) begin
          st_d    = ST_OVF;
          state_d = S_OUT;
        end
      end
      S_TRIAL: begin
        if (s_q > MAX_S) begin
          st_d    = ST_INEXACT;
          state_d = S_OUT;
        end else begin
          ma_d    = mag_a;
          mb_d    = mag_b;
          sel_a_d = !e[6];
          cnt_d   = e[6] ? 7'(-e) : e;
          state_d = S_DSCALE;
        end
      end
      S_DSCALE: begin
        if (cnt_q == 7'd0) begin
          if (minneg1) begin
            s_d     = s_q + 5'd1;
            state_d = S_TRIAL;
          end else begin
            state_d = S_DWAIT;
          end
        end else if (tgt_ovf) begin
          s_d     = s_q + 5'd1;
          state_d = S_TRIAL;
        end else begin
          if (sel_a_q) begin
            ma_d = tgt10;
          end else begin
            mb_d = tgt10;
          end
          cnt_d = cnt_q - 7'd1;
        end
      end
      S_DWAIT: begin
        if (div_stat.done) begin
          if (div_stat.exact) begin
            rm_d    = div_quot;
            rn_d    = ac_q[63] ^ bc_q[63];
            rs_d    = s_q;
            state_d = S_STRIP;
          end else begin
            s_d     = s_q + 5'd1;
            state_d = S_TRIAL;
          end
        end
      end
      S_STRIP: begin
        if (rm_q == 64'd0) begin
          rs_d    = '0;
          state_d = S_OUT;
        end else if (rs_q == 5'd0) begin
          state_d = S_OUT;
        end else begin
          state_d = S_SWAIT;
        end
      end
      S_SWAIT: begin
        if (div_stat.done) begin
          if (div_stat.exact) begin
            rm_d    = div_quot;
            rs_d    = rs_q - 5'd1;
            state_d = S_STRIP;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_CSCALE: begin
        if (cnt_q == 7'd0) begin
          state_d = S_CCMP;
        end else begin
          w_d   = 128'((w_q << 3) + (w_q << 1));
          cnt_d = cnt_q - 7'd1;
        end
      end
      S_CCMP: begin
        // Both operands share a sign here; for negatives the larger magnitude is smaller.
        if (ac_q[63] ? gt : lt) begin
          order_d = ORD_LESS;
        end else if (ac_q[63] ? lt : gt) begin
          order_d = ORD_GREATER;
        end else begin
          order_d = ORD_EQUAL;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    ac_q    <= ac_d;
    bc_q    <= bc_d;
    as_q    <= as_d;
    bs_q    <= bs_d;
    ma_q    <= ma_d;
    mb_q    <= mb_d;
    sb_q    <= sb_d;
    sel_a_q <= sel_a_d;
    cnt_q   <= cnt_d;
    s_q     <= s_d;
    p_q     <= p_d;
    q_q     <= q_d;
    w_q     <= w_d;
    rm_q    <= rm_d;
    rn_q    <= rn_d;
    rs_q    <= rs_d;
    order_q <= order_d;
    st_q    <= st_d;
  end

  assign in_stall_o           = (state_q != S_IDLE);
  assign out_valid_o          = (state_q == S_OUT);
  assign status_o             = st_q;
  assign result_coefficient_o = (st_q != ST_OK) ? 64'd0 :
                                (rn_q ? 64'(~rm_q + 64'd1) : rm_q);
  assign result_scale_o       = (st_q != ST_OK) ? 5'd0 : rs_q;
  assign order_o              = (st_q != ST_OK) ? ORD_EQUAL : order_q;

  a_fail_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> result_coefficient_o == 64'd0 &&
    result_scale_o == 5'd0 && order_o == ORD_EQUAL)
    else $error("failed result beat carries a value");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("input taken while a result beat is pending");

  a_scale_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> result_scale_o <= MAX_S)
    else $error("result scale above limit");

  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o)
    else $error("result beat repeated");

endmodule

/* hw/rtl/fsda_div.sv */
// Bit-serial restoring divider for unsigned 64-bit magnitudes.
module fsda_div
  import fsda_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic [63:0] quot_o,
  output div_stat_t   stat_o
);

  logic [63:0] rem_q, rem_d;
  logic [63:0] quo_q, quo_d;
  logic [63:0] den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [64:0] trial;
  logic        ge;

  assign trial = {rem_q, quo_q[63]};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? 64'(trial - {1'b0, den_q}) : trial[63:0];
      quo_d = {quo_q[62:0], ge};
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign quot_o       = quo_q;
  assign stat_o.done  = done_q;
  assign stat_o.exact = (rem_q == 64'd0);

endmodule
